FILE: src/hpm_pkg.sv
// ----------------------------------------------------------------------------
// hpm_pkg
// Shared types, constants and Q16.32 saturating helpers of the master step.
// ----------------------------------------------------------------------------
package hpm_pkg;

    localparam int QW        = 48;
    localparam int FRAC      = 32;
    localparam int CFG_W     = 47;
    localparam int MUL_STEPS = QW;
    localparam int DIV_STEPS = QW + FRAC;

    typedef logic signed [QW-1:0] q_t;
    typedef logic [QW-1:0] mag_t;

    localparam q_t QMAX = {1'b0, {(QW-1){1'b1}}};
    localparam q_t QMIN = {1'b1, {(QW-1){1'b0}}};
    localparam q_t TICK_DIV = q_t'(1000);

    typedef enum logic [2:0] {
        CFG_MAX_FORCE   = 3'd0,
        CFG_ERROR_GAIN  = 3'd1,
        CFG_POS_SCALE   = 3'd2,
        CFG_SPRING      = 3'd3,
        CFG_CHANNEL_EN  = 3'd4,
        CFG_CONTROL_EN  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        q_t master_position;
        q_t slave_velocity;
        q_t slave_velocity_energy;
        q_t virtual_force;
        q_t obstacle_force;
        q_t obstacle_energy;
        q_t speed_force;
        q_t speed_force_energy;
    } meas_word_t;

    typedef struct packed {
        q_t force_command;
        q_t command_position;
        q_t command_velocity;
        q_t error_force;
        q_t command_energy;
    } cmd_word_t;

    typedef enum logic [5:0] {
        ST_IDLE, ST_X, ST_V,
        ST_CE_M1, ST_CE_M2, ST_CE_ADD, ST_CP_M,
        ST_VE_SUB, ST_VE_M, ST_VE_OBS, ST_VE_TK, ST_VE_SUBE, ST_VE_CHK,
        ST_VE_RB, ST_VE_NUM, ST_VE_DIV, ST_VE_SUB2, ST_VE_M2, ST_VE_M3, ST_VE_SUBE2,
        ST_FC_OBS, ST_FC_TK, ST_FC_SUBE, ST_FC_CHK, ST_FC_RB, ST_FC_NUM,
        ST_FC_DIV, ST_FC_M, ST_FC_SUBE2, ST_FC_NEXT,
        ST_SUM1, ST_SUM2,
        ST_MS_D, ST_MS_M, ST_MS_NET, ST_MS_V, ST_MS_DIV, ST_MS_P, ST_MS_D2, ST_MS_M2,
        ST_CLAMP, ST_OUT_M, ST_DONE
    } st_t;

    function automatic q_t qadd(q_t a, q_t b);
        logic signed [QW:0] s;
        begin
            s = {a[QW-1], a} + {b[QW-1], b};
            if (s[QW] != s[QW-1])
                return s[QW] ? QMIN : QMAX;
            return s[QW-1:0];
        end
    endfunction

    function automatic q_t qsub(q_t a, q_t b);
        logic signed [QW:0] s;
        begin
            s = {a[QW-1], a} - {b[QW-1], b};
            if (s[QW] != s[QW-1])
                return s[QW] ? QMIN : QMAX;
            return s[QW-1:0];
        end
    endfunction

    function automatic q_t qneg(q_t a);
        begin
            if (a == QMIN)
                return QMAX;
            return -a;
        end
    endfunction

    function automatic q_t qsat10(q_t a);
        logic signed [QW+3:0] w;
        logic signed [QW+3:0] p;
        begin
            w = {{4{a[QW-1]}}, a};
            p = (w <<< 3) + (w <<< 1);
            if (p[QW+3:QW-1] != {5{p[QW+3]}})
                return p[QW+3] ? QMIN : QMAX;
            return p[QW-1:0];
        end
    endfunction

    function automatic logic pos_product(q_t a, q_t b);
        begin
            return (a != '0) && (b != '0) && (a[QW-1] == b[QW-1]);
        end
    endfunction

    function automatic mag_t qmag(q_t a);
        begin
            return a[QW-1] ? mag_t'(-a) : mag_t'(a);
        end
    endfunction

endpackage

FILE: src/hpm_meas_if.sv
// ----------------------------------------------------------------------------
// hpm_meas_if
// Valid/ready channel carrying one servo-tick measurement word.
// ----------------------------------------------------------------------------
interface hpm_meas_if;
    logic valid;
    logic ready;
    hpm_pkg::meas_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/hpm_cmd_if.sv
// ----------------------------------------------------------------------------
// hpm_cmd_if
// Valid/ready channel carrying one force command word.
// ----------------------------------------------------------------------------
interface hpm_cmd_if;
    logic valid;
    logic ready;
    hpm_pkg::cmd_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/hpm_mul.sv
// ----------------------------------------------------------------------------
// hpm_mul
// Bit-serial Q16.32 multiplier: one multiplier bit per cycle, saturated result.
// ----------------------------------------------------------------------------
module hpm_mul (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  hpm_pkg::q_t   a,
    input  hpm_pkg::q_t   b,
    output logic          done,
    output hpm_pkg::q_t   y
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [5:0]           cnt_reg, cnt_next;
    hpm_pkg::mag_t        ma_reg, ma_next;
    hpm_pkg::mag_t        hi_reg, hi_next;
    hpm_pkg::mag_t        lo_reg, lo_next;
    logic                 neg_reg, neg_next;
    hpm_pkg::q_t          y_reg, y_next;
    logic [hpm_pkg::QW:0] sum;
    logic [2*hpm_pkg::QW-1:0] prod;
    logic                 big;
    hpm_pkg::mag_t        m;
    hpm_pkg::q_t          fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg  <= ma_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        neg_reg <= neg_next;
        y_reg   <= y_next;
    end

    always_comb
    begin
        sum  = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, ma_reg} : '0);
        prod = {hi_reg, lo_reg};
        big  = |prod[2*hpm_pkg::QW-1:hpm_pkg::QW+hpm_pkg::FRAC-1];
        m    = prod[hpm_pkg::QW+hpm_pkg::FRAC-1:hpm_pkg::FRAC];
        if (neg_reg)
            fin = big ? hpm_pkg::QMIN : -hpm_pkg::q_t'(m);
        else
            fin = big ? hpm_pkg::QMAX : hpm_pkg::q_t'(m);

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        ma_next   = ma_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        neg_next  = neg_reg;
        y_next    = y_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            ma_next   = hpm_pkg::qmag(a);
            hi_next   = '0;
            lo_next   = hpm_pkg::qmag(b);
            neg_next  = a[hpm_pkg::QW-1] ^ b[hpm_pkg::QW-1];
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'(hpm_pkg::MUL_STEPS))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                y_next    = fin;
            end
            else
            begin
                hi_next  = sum[hpm_pkg::QW:1];
                lo_next  = {sum[0], lo_reg[hpm_pkg::QW-1:1]};
                cnt_next = cnt_reg + 6'd1;
            end
        end
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule

FILE: src/hpm_div.sv
// ----------------------------------------------------------------------------
// hpm_div
// Bit-serial restoring divider: Q16.32 quotient or plain integer quotient.
// ----------------------------------------------------------------------------
module hpm_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          int_mode,
    input  hpm_pkg::q_t   n,
    input  hpm_pkg::q_t   d,
    output logic          done,
    output hpm_pkg::q_t   y
);

    localparam int DW = hpm_pkg::DIV_STEPS;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [6:0]           cnt_reg, cnt_next;
    logic [DW-1:0]        num_reg, num_next;
    hpm_pkg::mag_t        md_reg, md_next;
    hpm_pkg::mag_t        r_reg, r_next;
    logic [hpm_pkg::QW-1:0] q_reg, q_next;
    logic                 ovf_reg, ovf_next;
    logic                 neg_reg, neg_next;
    hpm_pkg::q_t          y_reg, y_next;
    logic [hpm_pkg::QW:0] r_sh;
    logic                 ge;
    logic [hpm_pkg::QW:0] r_new;
    logic [hpm_pkg::QW:0] nq;
    logic                 big;
    hpm_pkg::q_t          fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        md_reg  <= md_next;
        r_reg   <= r_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
        neg_reg <= neg_next;
        y_reg   <= y_next;
    end

    always_comb
    begin
        r_sh  = {r_reg, num_reg[DW-1]};
        ge    = r_sh >= {1'b0, md_reg};
        r_new = ge ? (r_sh - {1'b0, md_reg}) : r_sh;
        nq    = {q_reg, ge};
        big   = ovf_reg || q_reg[hpm_pkg::QW-1];
        if (neg_reg)
            fin = big ? hpm_pkg::QMIN : -hpm_pkg::q_t'(q_reg);
        else
            fin = big ? hpm_pkg::QMAX : hpm_pkg::q_t'(q_reg);

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        md_next   = md_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        neg_next  = neg_reg;
        y_next    = y_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            if (int_mode)
                num_next = {{hpm_pkg::FRAC{1'b0}}, hpm_pkg::qmag(n)};
            else
                num_next = {hpm_pkg::qmag(n), {hpm_pkg::FRAC{1'b0}}};
            md_next   = hpm_pkg::qmag(d);
            r_next    = '0;
            q_next    = '0;
            ovf_next  = 1'b0;
            neg_next  = n[hpm_pkg::QW-1] ^ d[hpm_pkg::QW-1];
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 7'(DW))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                y_next    = fin;
            end
            else
            begin
                num_next = {num_reg[DW-2:0], 1'b0};
                r_next   = r_new[hpm_pkg::QW-1:0];
                if (!ovf_reg)
                begin
                    if (nq > {1'b0, 1'b1, {(hpm_pkg::QW-1){1'b0}}})
                        ovf_next = 1'b1;
                    else
                        q_next = nq[hpm_pkg::QW-1:0];
                end
                cnt_next = cnt_reg + 7'd1;
            end
        end
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule

FILE: src/haptic_passivity_master_step.sv
// ----------------------------------------------------------------------------
// haptic_passivity_master_step
// Master servo tick: passivity observers/controllers and virtual mass-spring.
// ----------------------------------------------------------------------------
// One measurement word per servo tick; values are signed Q16.32. The first
// word after reset only latches the home position and yields no command.
// Every later word runs a sequencer over one bit-serial multiplier and one
// bit-serial divider. A tick does the least work when every controller is
// disabled and the most when every observer takes energy and every passivity
// controller fires. A new word is taken once the previous command has been
// loaded into the output register.
module haptic_passivity_master_step (
    input  logic                        clk,
    input  logic                        rst_n,
    hpm_meas_if.sink                    meas,
    hpm_cmd_if.source                   cmd,
    input  logic                        write_enable,
    input  logic [2:0]                  write_index,
    input  logic [hpm_pkg::CFG_W-1:0]   write_data
);

    hpm_pkg::st_t        state_reg, state_next;
    logic                first_reg, first_next;
    logic                issued_reg, issued_next;
    logic                ch_reg, ch_next;
    logic                out_valid_reg, out_valid_next;
    hpm_pkg::cmd_word_t  out_data_reg, out_data_next;

    logic [hpm_pkg::CFG_W-1:0] max_force_reg, gain_reg, scale_reg, spring_reg;
    logic [2:0]          chan_en_reg, ctrl_en_reg;

    hpm_pkg::q_t pos_reg, pos_next, vs_reg, vs_next, vse_reg, vse_next;
    hpm_pkg::q_t fs_reg, fs_next, fe_reg, fe_next, fee_reg, fee_next;
    hpm_pkg::q_t fv_reg, fv_next, fvse_reg, fvse_next;
    hpm_pkg::q_t home_reg, home_next, prev_reg, prev_next;
    hpm_pkg::q_t mp_reg, mp_next, mv_reg, mv_next, ce_reg, ce_next;
    hpm_pkg::q_t vce_reg, vce_next, oce_reg, oce_next, sce_reg, sce_next;
    hpm_pkg::q_t x_reg, x_next, v_reg, v_next, t_reg, t_next, cp_reg, cp_next;
    hpm_pkg::q_t fve_reg, fve_next, taken_reg, taken_next, fm_reg, fm_next;

    logic        mul_start, mul_done, div_start, div_done, div_int;
    hpm_pkg::q_t mul_a, mul_b, mul_y, div_n, div_d, div_y;

    hpm_pkg::q_t scale_q, gain_q, spring_q, lim_q;
    hpm_pkg::q_t f_cur, e_cur, se_cur, e_tmp;
    logic        pc_cur;

    hpm_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .y     (mul_y)
    );

    hpm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .int_mode (div_int),
        .n        (div_n),
        .d        (div_d),
        .done     (div_done),
        .y        (div_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hpm_pkg::ST_IDLE;
            first_reg     <= 1'b1;
            issued_reg    <= 1'b0;
            ch_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            max_force_reg <= hpm_pkg::CFG_W'(64'd42949672960);
            gain_reg      <= hpm_pkg::CFG_W'(64'd42949673);
            scale_reg     <= hpm_pkg::CFG_W'(64'd42949672960);
            spring_reg    <= hpm_pkg::CFG_W'(64'd4294967296);
            chan_en_reg   <= 3'd5;
            ctrl_en_reg   <= 3'd5;
            home_reg      <= '0;
            prev_reg      <= '0;
            mp_reg        <= '0;
            mv_reg        <= '0;
            ce_reg        <= '0;
            vce_reg       <= '0;
            oce_reg       <= '0;
            sce_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            issued_reg    <= issued_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
            home_reg      <= home_next;
            prev_reg      <= prev_next;
            mp_reg        <= mp_next;
            mv_reg        <= mv_next;
            ce_reg        <= ce_next;
            vce_reg       <= vce_next;
            oce_reg       <= oce_next;
            sce_reg       <= sce_next;
            if (write_enable)
            begin
                unique case (hpm_pkg::cfg_idx_t'(write_index))
                    hpm_pkg::CFG_MAX_FORCE:  max_force_reg <= write_data;
                    hpm_pkg::CFG_ERROR_GAIN: gain_reg      <= write_data;
                    hpm_pkg::CFG_POS_SCALE:  scale_reg     <= write_data;
                    hpm_pkg::CFG_SPRING:     spring_reg    <= write_data;
                    hpm_pkg::CFG_CHANNEL_EN: chan_en_reg   <= write_data[2:0];
                    hpm_pkg::CFG_CONTROL_EN: ctrl_en_reg   <= write_data[2:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        pos_reg      <= pos_next;
        vs_reg       <= vs_next;
        vse_reg      <= vse_next;
        fs_reg       <= fs_next;
        fe_reg       <= fe_next;
        fee_reg      <= fee_next;
        fv_reg       <= fv_next;
        fvse_reg     <= fvse_next;
        x_reg        <= x_next;
        v_reg        <= v_next;
        t_reg        <= t_next;
        cp_reg       <= cp_next;
        fve_reg      <= fve_next;
        taken_reg    <= taken_next;
        fm_reg       <= fm_next;
    end

    always_comb
    begin
        scale_q  = {1'b0, scale_reg};
        gain_q   = {1'b0, gain_reg};
        spring_q = {1'b0, spring_reg};
        lim_q    = {1'b0, max_force_reg};
        f_cur    = ch_reg ? fv_reg : fe_reg;
        e_cur    = ch_reg ? sce_reg : oce_reg;
        se_cur   = ch_reg ? fvse_reg : fee_reg;
        pc_cur   = ch_reg ? ctrl_en_reg[2] : ctrl_en_reg[0];
        e_tmp    = e_cur;

        state_next     = state_reg;
        first_next     = first_reg;
        ch_next        = ch_reg;
        out_valid_next = cmd.ready ? 1'b0 : out_valid_reg;
        out_data_next  = out_data_reg;
        pos_next  = pos_reg;  vs_next   = vs_reg;   vse_next  = vse_reg;
        fs_next   = fs_reg;   fe_next   = fe_reg;   fee_next  = fee_reg;
        fv_next   = fv_reg;   fvse_next = fvse_reg;
        home_next = home_reg; prev_next = prev_reg;
        mp_next   = mp_reg;   mv_next   = mv_reg;   ce_next   = ce_reg;
        vce_next  = vce_reg;  oce_next  = oce_reg;  sce_next  = sce_reg;
        x_next    = x_reg;    v_next    = v_reg;    t_next    = t_reg;
        cp_next   = cp_reg;   fve_next  = fve_reg;  taken_next = taken_reg;
        fm_next   = fm_reg;

        mul_start = 1'b0;
        mul_a     = mp_reg;
        mul_b     = scale_q;
        div_start = 1'b0;
        div_int   = 1'b0;
        div_n     = t_reg;
        div_d     = fve_reg;
        meas.ready = 1'b0;

        unique case (state_reg)
            hpm_pkg::ST_IDLE:
            begin
                meas.ready = 1'b1;
                if (meas.valid)
                begin
                    pos_next  = meas.data.master_position;
                    vs_next   = meas.data.slave_velocity;
                    vse_next  = meas.data.slave_velocity_energy;
                    fs_next   = meas.data.virtual_force;
                    fe_next   = meas.data.obstacle_force;
                    fee_next  = meas.data.obstacle_energy;
                    fv_next   = meas.data.speed_force;
                    fvse_next = meas.data.speed_force_energy;
                    if (first_reg)
                    begin
                        home_next  = meas.data.master_position;
                        first_next = 1'b0;
                    end
                    else
                        state_next = hpm_pkg::ST_X;
                end
            end
            hpm_pkg::ST_X:
            begin
                x_next     = hpm_pkg::qsub(pos_reg, home_reg);
                state_next = hpm_pkg::ST_V;
            end
            hpm_pkg::ST_V:
            begin
                v_next    = hpm_pkg::qsub(x_reg, prev_reg);
                prev_next = x_reg;
                if (hpm_pkg::pos_product(fs_reg, mp_reg))
                    state_next = hpm_pkg::ST_CE_M1;
                else
                    state_next = hpm_pkg::ST_CP_M;
            end
            hpm_pkg::ST_CE_M1:
            begin
                mul_a = fs_reg;
                mul_b = mp_reg;
                mul_start = !issued_reg;
                if (mul_done)
                begin
                    t_next     = mul_y;
                    state_next = hpm_pkg::ST_CE_M2;
                end
            end
            hpm_pkg::ST_CE_M2:
            begin
                mul_a = t_reg;
                mul_b = scale_q;
                mul_start = !issued_reg;
                if (mul_done)
                begin
                    t_next     = mul_y;
                    state_next = hpm_pkg::ST_CE_ADD;
                end
            end
            hpm_pkg::ST_CE_ADD:
            begin
                ce_next    = hpm_pkg::qadd(ce_reg, t_reg);
                state_next = hpm_pkg::ST_CP_M;
            end
            hpm_pkg::ST_CP_M:
            begin
                mul_a = mp_reg;
                mul_b = scale_q;
                mul_start = !issued_reg;
                if (mul_done)
                begin
                    cp_next    = mul_y;
                    state_next = hpm_pkg::ST_VE_SUB;
                end
            end
            hpm_pkg::ST_VE_SUB:
            begin
                t_next     = hpm_pkg::qsub(cp_reg, vs_reg);
                state_next = hpm_pkg::ST_VE_M;
            end
            hpm_pkg::ST_VE_M:
            begin
                mul_a = gain_q;
                mul_b = t_reg;
                mul_start = !issued_reg;
                if (mul_done)
                begin
                    fve_next   = hpm_pkg::qneg(mul_y);
                    state_next = hpm_pkg::ST_VE_OBS;
                end
            end
            hpm_pkg::ST_VE_OBS:
            begin
                taken_next = '0;
                if (hpm_pkg::pos_product(fve_reg, vs_reg))
                    state_next = hpm_pkg::ST_VE_TK;
                else
                    state_next = hpm_pkg::ST_VE_CHK;
            end
            hpm_pkg::ST_VE_TK:
            begin
                mul_a = fve_reg;
                mul_b = vs_reg;
                mul_start = !issued_reg;
                if (mul_done)
                begin
                    taken_next = mul_y;
                    state_next = hpm_pkg::ST_VE_SUBE;
                end
            end
            hpm_pkg::ST_VE_SUBE:
            begin
                vce_next   = hpm_pkg::qsub(vce_reg, taken_reg);
                state_next = hpm_pkg::ST_VE_CHK;
            end
            hpm_pkg::ST_VE_CHK:
            begin
                ch_next = 1'b0;
                if (ctrl_en_reg[1] && hpm_pkg::qadd(vce_reg, vse_reg) < 0)
                    state_next = hpm_pkg::ST_VE_RB;
                else
                    state_next = hpm_pkg::ST_FC_OBS;
            end
            hpm_pkg::ST_VE_RB:
            begin
                vce_next   = hpm_pkg::qadd(vce_reg, taken_reg);
                state_next = hpm_pkg::ST_VE_NUM;
            end
            hpm_pkg::ST_VE_NUM:
            begin
                t_next = hpm_pkg::qadd(vce_reg, vse_reg);
                if (fve_reg == '0)
                begin
                    vs_next    = '0;
                    state_next = hpm_pkg::ST_VE_SUB2;
                end
                else
                    state_next = hpm_pkg::ST_VE_DIV;
            end
            hpm_pkg::ST_VE_DIV:
            begin
                div_n = t_reg;
                div_d = fve_reg;
                div_start = !issued_reg;
                if (div_done)
                begin
                    vs_next    = div_y;
                    state_next = hpm_pkg::ST_VE_SUB2;
                end
            end
            hpm_pkg::ST_VE_SUB2:
            begin
                t_next     = hpm_pkg::qsub(cp_reg, vs_reg);
                state_next = hpm_pkg::ST_VE_M2;
            end
            hpm_pkg::ST_VE_M2:
            begin
                mul_a = gain_q;
                mul_b = t_reg;
                mul_start = !issued_reg;
                if (mul_done)
                begin
                    fve_next   = hpm_pkg::qneg(mul_y);
                    state_next = hpm_pkg::ST_VE_M3;
                end
            end
            hpm_pkg::ST_VE_M3:
            begin
                mul_a = fve_reg;
                mul_b = vs_reg;
                mul_start = !issued_reg;
                if (mul_done)
                begin
                    t_next     = mul_y;
                    state_next = hpm_pkg::ST_VE_SUBE2;
                end
            end
            hpm_pkg::ST_VE_SUBE2:
            begin
                vce_next   = hpm_pkg::qsub(vce_reg, t_reg);
                state_next = hpm_pkg::ST_FC_OBS;
            end
            hpm_pkg::ST_FC_OBS:
            begin
                taken_next = '0;
                if (hpm_pkg::pos_product(f_cur, mv_reg))
                    state_next = hpm_pkg::ST_FC_TK;
                else
                    state_next = hpm_pkg::ST_FC_CHK;
            end
            hpm_pkg::ST_FC_TK:
            begin
                mul_a = f_cur;
                mul_b = mv_reg;
                mul_start = !issued_reg;
                if (mul_done)
                begin
                    taken_next = mul_y;
                    state_next = hpm_pkg::ST_FC_SUBE;
                end
            end
            hpm_pkg::ST_FC_SUBE:
            begin
                e_tmp      = hpm_pkg::qsub(e_cur, taken_reg);
                state_next = hpm_pkg::ST_FC_CHK;
            end
            hpm_pkg::ST_FC_CHK:
            begin
                if (pc_cur && hpm_pkg::qadd(e_cur, se_cur) < 0)
                    state_next = hpm_pkg::ST_FC_RB;
                else
                    state_next = hpm_pkg::ST_FC_NEXT;
            end
            hpm_pkg::ST_FC_RB:
            begin
                e_tmp      = hpm_pkg::qadd(e_cur, taken_reg);
                state_next = hpm_pkg::ST_FC_NUM;
            end
            hpm_pkg::ST_FC_NUM:
            begin
                t_next = hpm_pkg::qadd(e_cur, se_cur);
                if (mv_reg == '0)
                begin
                    if (ch_reg)
                        fv_next = '0;
                    else
                        fe_next = '0;
                    state_next = hpm_pkg::ST_FC_M;
                end
                else
                    state_next = hpm_pkg::ST_FC_DIV;
            end
            hpm_pkg::ST_FC_DIV:
            begin
                div_n = t_reg;
                div_d = mv_reg;
                div_start = !issued_reg;
                if (div_done)
                begin
                    if (ch_reg)
                        fv_next = div_y;
                    else
                        fe_next = div_y;
                    state_next = hpm_pkg::ST_FC_M;
                end
            end
            hpm_pkg::ST_FC_M:
            begin
                mul_a = f_cur;
                mul_b = mv_reg;
                mul_start = !issued_reg;
                if (mul_done)
                begin
                    t_next     = mul_y;
                    state_next = hpm_pkg::ST_FC_SUBE2;
                end
            end
            hpm_pkg::ST_FC_SUBE2:
            begin
                e_tmp      = hpm_pkg::qsub(e_cur, t_reg);
                state_next = hpm_pkg::ST_FC_NEXT;
            end
            hpm_pkg::ST_FC_NEXT:
            begin
                if (ch_reg)
                    state_next = hpm_pkg::ST_SUM1;
                else
                begin
                    ch_next    = 1'b1;
                    state_next = hpm_pkg::ST_FC_OBS;
                end
            end
            hpm_pkg::ST_SUM1:
            begin
                if (!chan_en_reg[0])
                    fe_next = '0;
                if (!chan_en_reg[1])
                    fve_next = '0;
                fm_next = hpm_pkg::qadd(chan_en_reg[0] ? fe_reg : '0,
                                        chan_en_reg[1] ? fve_reg : '0);
                state_next = hpm_pkg::ST_SUM2;
            end
            hpm_pkg::ST_SUM2:
            begin
                fm_next = hpm_pkg::qadd(fm_reg, chan_en_reg[2] ? fv_reg : '0);
                if (ctrl_en_reg == '0)
                begin
                    mp_next    = x_reg;
                    mv_next    = v_reg;
                    state_next = hpm_pkg::ST_CLAMP;
                end
                else
                    state_next = hpm_pkg::ST_MS_D;
            end
            hpm_pkg::ST_MS_D:
            begin
                t_next     = hpm_pkg::qsub(mp_reg, x_reg);
                state_next = hpm_pkg::ST_MS_M;
            end
            hpm_pkg::ST_MS_M:
            begin
                mul_a = spring_q;
                mul_b = t_reg;
                mul_start = !issued_reg;
                if (mul_done)
                begin
                    t_next     = mul_y;
                    state_next = hpm_pkg::ST_MS_NET;
                end
            end
            hpm_pkg::ST_MS_NET:
            begin
                t_next     = hpm_pkg::qadd(hpm_pkg::qneg(t_reg), fm_reg);
                state_next = hpm_pkg::ST_MS_V;
            end
            hpm_pkg::ST_MS_V:
            begin
                mv_next    = hpm_pkg::qadd(mv_reg, hpm_pkg::qsat10(t_reg));
                state_next = hpm_pkg::ST_MS_DIV;
            end
            hpm_pkg::ST_MS_DIV:
            begin
                div_n   = mv_reg;
                div_d   = hpm_pkg::TICK_DIV;
                div_int = 1'b1;
                div_start = !issued_reg;
                if (div_done)
                begin
                    t_next     = div_y;
                    state_next = hpm_pkg::ST_MS_P;
                end
            end
            hpm_pkg::ST_MS_P:
            begin
                mp_next    = hpm_pkg::qadd(mp_reg, t_reg);
                state_next = hpm_pkg::ST_MS_D2;
            end
            hpm_pkg::ST_MS_D2:
            begin
                t_next     = hpm_pkg::qsub(mp_reg, x_reg);
                state_next = hpm_pkg::ST_MS_M2;
            end
            hpm_pkg::ST_MS_M2:
            begin
                mul_a = spring_q;
                mul_b = t_reg;
                mul_start = !issued_reg;
                if (mul_done)
                begin
                    fm_next    = mul_y;
                    state_next = hpm_pkg::ST_CLAMP;
                end
            end
            hpm_pkg::ST_CLAMP:
            begin
                if (fm_reg > lim_q)
                    fm_next = lim_q;
                else if (fm_reg < -lim_q)
                    fm_next = -lim_q;
                state_next = hpm_pkg::ST_OUT_M;
            end
            hpm_pkg::ST_OUT_M:
            begin
                mul_a = mp_reg;
                mul_b = scale_q;
                mul_start = !issued_reg;
                if (mul_done)
                begin
                    cp_next    = mul_y;
                    state_next = hpm_pkg::ST_DONE;
                end
            end
            hpm_pkg::ST_DONE:
            begin
                if (!out_valid_reg || cmd.ready)
                begin
                    out_data_next.force_command    = fm_reg;
                    out_data_next.command_position = cp_reg;
                    out_data_next.command_velocity = mv_reg;
                    out_data_next.error_force      = fve_reg;
                    out_data_next.command_energy   = ce_reg;
                    out_valid_next = 1'b1;
                    state_next     = hpm_pkg::ST_IDLE;
                end
            end
            default:
                state_next = hpm_pkg::ST_IDLE;
        endcase

        if (ch_reg)
            sce_next = e_tmp;
        else
            oce_next = e_tmp;

        issued_next = issued_reg;
        if (mul_start || div_start)
            issued_next = 1'b1;
        if (mul_done || div_done)
            issued_next = 1'b0;
    end

    assign cmd.valid = out_valid_reg;
    assign cmd.data  = out_data_reg;

endmodule
